// ===== rtl/core/osm_pkg.sv =====
// Package for the order-statistic multiset: widths, opcodes, status codes, the
// sequencer state type and the memory request type. No dependencies.
package osm_pkg;

   localparam int CAPACITY = 1024;
   localparam int ADDR_W   = $clog2(CAPACITY);
   localparam int COUNT_W  = $clog2(CAPACITY + 1);
   localparam int KEY_W    = 32;
   localparam int POS_W    = 11;
   localparam int OP_W     = 3;
   localparam int STAT_W   = 2;

   localparam logic [OP_W-1:0] OP_INSERT = 3'd0;
   localparam logic [OP_W-1:0] OP_DELETE = 3'd1;
   localparam logic [OP_W-1:0] OP_RANK   = 3'd2;
   localparam logic [OP_W-1:0] OP_KTH    = 3'd3;
   localparam logic [OP_W-1:0] OP_PRED   = 3'd4;
   localparam logic [OP_W-1:0] OP_SUCC   = 3'd5;

   localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
   localparam logic [STAT_W-1:0] ST_MISS = 2'd1;
   localparam logic [STAT_W-1:0] ST_FULL = 2'd2;

   typedef enum logic [7:0] {
      S_IDLE   = 8'b0000_0001,
      S_SEARCH = 8'b0000_0010,
      S_WAIT   = 8'b0000_0100,
      S_FETCH  = 8'b0000_1000,
      S_SHIFT  = 8'b0001_0000,
      S_PUT    = 8'b0010_0000,
      S_DONE   = 8'b0100_0000,
      S_OUT    = 8'b1000_0000
   } state_type;

   // Memory port request from the sequencer.
   typedef struct packed {
      logic              rd;
      logic [ADDR_W-1:0] raddr;
      logic              wr;
      logic [ADDR_W-1:0] waddr;
      logic [KEY_W-1:0]  wdata;
   } mem_req_type;

endpackage

// ===== rtl/core/osm_ram.sv =====
// Simple dual-port key store with a registered read port.
// Depends on osm_pkg for widths.
module osm_ram
   import osm_pkg::*;
(
   input  logic              clock,
   input  mem_req_type       req,
   output logic [KEY_W-1:0]  rdata
);

   logic [KEY_W-1:0] mem [CAPACITY];

   // Write and registered read.
   always_ff @(posedge clock) begin
      if (req.wr) begin
         mem[req.waddr] <= req.wdata;
      end
      if (req.rd) begin
         rdata <= mem[req.raddr];
      end
   end

endmodule

// ===== rtl/core/order_statistic_multiset.sv =====
// Top level of the order-statistic multiset: sequencer around the key store.
// Depends on osm_pkg and osm_ram.
//
// One transaction on req_ carries an opcode, a signed key and a position;
// each gives exactly one transaction on rsp_ with an answer and a status.
// Keys are held sorted, biased by flipping the sign bit, in a 1024-entry
// memory with a registered read. An item is taken only when the block is idle.
// A binary search makes eleven probes at most, each a read in S_SEARCH and a
// compare in S_WAIT. Insert and delete then shift the tail of the array one
// entry at a time (read then write), a pace that the memory's single read
// port sets.
// The result sits in an output register; while rsp_tready is low it holds,
// and the next request is accepted in the cycle after the result has been taken.
// Reset empties the multiset at once (the count returns to zero); memory
// contents are not cleared and need no clearing pass.
module order_statistic_multiset
   import osm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // opcode[2:0], key[34:3], position[45:35]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata    // answer[31:0], status[33:32]
);

   state_type          state_ff, state_in;
   logic [OP_W-1:0]    op_ff, op_in;
   logic [KEY_W-1:0]   key_ff, key_in;
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic [COUNT_W-1:0] cnt_ff, cnt_in;
   logic [COUNT_W-1:0] lo_ff, lo_in, hi_ff, hi_in;
   logic [COUNT_W-1:0] idx_ff, idx_in;
   logic [KEY_W-1:0]   ans_ff, ans_in;
   logic [STAT_W-1:0]  st_ff, st_in;
   logic [COUNT_W-1:0] mid;
   logic [KEY_W-1:0]   rdata;
   logic               use_le;
   mem_req_type        mreq;

   osm_ram u_ram (.clock(clock), .req(mreq), .rdata(rdata));

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = (state_ff == S_OUT);
   assign rsp_tdata  = {6'd0, st_ff, ans_ff};
   assign mid        = lo_ff + ((hi_ff - lo_ff) >> 1);
   // Insert and successor search for the count at or below the key.
   assign use_le     = (op_ff == OP_INSERT) || (op_ff == OP_SUCC);

   // Sequencer.
   always_comb begin
      state_in = state_ff;
      op_in = op_ff; key_in = key_ff; pos_in = pos_ff; cnt_in = cnt_ff;
      lo_in = lo_ff; hi_in = hi_ff; idx_in = idx_ff;
      ans_in = ans_ff; st_in = st_ff;
      mreq = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               op_in  = req_tdata[2:0];
               key_in = req_tdata[34:3] ^ {1'b1, {(KEY_W-1){1'b0}}};
               pos_in = req_tdata[45:35];
               lo_in  = '0;
               hi_in  = cnt_ff;
               ans_in = '0;
               st_in  = ST_OK;
               state_in = S_SEARCH;
            end
         end
         S_SEARCH: begin
            priority if (op_ff == OP_KTH) begin
               if (pos_ff == '0 || COUNT_W'(pos_ff) > cnt_ff) begin
                  st_in = ST_MISS; state_in = S_OUT;
               end else begin
                  mreq.rd = 1'b1;
                  mreq.raddr = ADDR_W'(pos_ff - 1'b1);
                  state_in = S_DONE;
               end
            end else if (op_ff > OP_SUCC) begin
               st_in = ST_MISS; state_in = S_OUT;
            end else if (op_ff == OP_INSERT && cnt_ff == COUNT_W'(CAPACITY)) begin
               st_in = ST_FULL; state_in = S_OUT;
            end else if (lo_ff < hi_ff) begin
               mreq.rd = 1'b1;
               mreq.raddr = mid[ADDR_W-1:0];
               state_in = S_WAIT;
            end else begin
               state_in = S_FETCH;
            end
         end
         S_WAIT: begin
            if (rdata < key_ff || (use_le && rdata == key_ff)) begin
               lo_in = mid + 1'b1;
            end else begin
               hi_in = mid;
            end
            state_in = S_SEARCH;
         end
         S_FETCH: begin
            // lo_ff now holds the search count.
            unique case (op_ff)
               OP_RANK: begin
                  ans_in = KEY_W'(lo_ff) + 1'b1; state_in = S_OUT;
               end
               OP_PRED: begin
                  if (lo_ff == '0) begin
                     st_in = ST_MISS; state_in = S_OUT;
                  end else begin
                     mreq.rd = 1'b1;
                     mreq.raddr = ADDR_W'(lo_ff - 1'b1);
                     state_in = S_DONE;
                  end
               end
               OP_SUCC, OP_DELETE: begin
                  if (lo_ff >= cnt_ff) begin
                     st_in = ST_MISS; state_in = S_OUT;
                  end else begin
                     mreq.rd = 1'b1;
                     mreq.raddr = lo_ff[ADDR_W-1:0];
                     state_in = S_DONE;
                  end
               end
               default: begin
                  // Insert: shift the tail upward from the top.
                  idx_in = cnt_ff;
                  state_in = S_SHIFT;
               end
            endcase
         end
         S_DONE: begin
            if (op_ff == OP_DELETE) begin
               if (rdata != key_ff) begin
                  st_in = ST_MISS; state_in = S_OUT;
               end else begin
                  idx_in = lo_ff;
                  state_in = S_SHIFT;
               end
            end else begin
               ans_in = rdata ^ {1'b1, {(KEY_W-1){1'b0}}};
               state_in = S_OUT;
            end
         end
         S_SHIFT: begin
            if (op_ff == OP_INSERT) begin
               if (idx_ff == lo_ff) begin
                  mreq.wr = 1'b1;
                  mreq.waddr = lo_ff[ADDR_W-1:0];
                  mreq.wdata = key_ff;
                  cnt_in = cnt_ff + 1'b1;
                  state_in = S_OUT;
               end else begin
                  mreq.rd = 1'b1;
                  mreq.raddr = ADDR_W'(idx_ff - 1'b1);
                  state_in = S_PUT;
               end
            end else begin
               if (idx_ff + 1'b1 >= cnt_ff) begin
                  cnt_in = cnt_ff - 1'b1;
                  state_in = S_OUT;
               end else begin
                  mreq.rd = 1'b1;
                  mreq.raddr = ADDR_W'(idx_ff + 1'b1);
                  state_in = S_PUT;
               end
            end
         end
         S_PUT: begin
            mreq.wr = 1'b1;
            mreq.wdata = rdata;
            if (op_ff == OP_INSERT) begin
               mreq.waddr = idx_ff[ADDR_W-1:0];
               idx_in = idx_ff - 1'b1;
            end else begin
               mreq.waddr = idx_ff[ADDR_W-1:0];
               idx_in = idx_ff + 1'b1;
            end
            state_in = S_SHIFT;
         end
         S_OUT: begin
            if (rsp_tready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      op_ff <= op_in; key_ff <= key_in; pos_ff <= pos_in;
      lo_ff <= lo_in; hi_ff <= hi_in; idx_ff <= idx_in;
      ans_ff <= ans_in; st_ff <= st_in;
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= COUNT_W'(CAPACITY)) else $error("count above capacity");
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      cnt_ff != $past(cnt_ff) |-> $past(state_ff) == S_SHIFT)
      else $error("count changed outside a shift");
   a_search_bounds: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SEARCH |-> lo_ff <= hi_ff) else $error("search bounds crossed");
   a_full_status: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && st_ff == ST_FULL |-> cnt_ff == COUNT_W'(CAPACITY))
      else $error("full reported while not full");

endmodule

// ===== tb/order_statistic_multiset_tb.sv =====
// Self-checking testbench for the order-statistic multiset: random and directed
// operations are predicted by a sorted-array model held in the bench.
// Depends on osm_pkg and the order_statistic_multiset RTL.
module order_statistic_multiset_tb
   import osm_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [POS_W-1:0]  position;
      logic [KEY_W-1:0]  key;
      logic [OP_W-1:0]   opcode;
   } op_item_type;

   // Status sits above the answer, as on rsp_tdata.
   typedef struct packed {
      logic [STAT_W-1:0] status;
      logic [KEY_W-1:0]  answer;
   } op_result_type;

   localparam int WATCHDOG_LIMIT = 20000;

   // Opcodes that the block does not define.
   localparam logic [OP_W-1:0] OP_UNUSED_LO = 3'd6;
   localparam logic [OP_W-1:0] OP_UNUSED_HI = 3'd7;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;

   op_item_type   pending_ops[$];
   op_result_type expected_results[$];
   logic signed [KEY_W-1:0] held_keys[$];
   int  failures = 0;
   int  send_idle_pct = 32;
   int  recv_idle_pct = 63;
   int  quiet_cycles = 0;

   order_statistic_multiset dut (.*);

   // Clock generation.
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Apply one operation to the bench's sorted array and return its result.
   function automatic op_result_type apply_op(op_item_type it);
      op_result_type r;
      logic signed [KEY_W-1:0] k;
      int below;
      int not_above;
      r.answer = '0;
      r.status = ST_OK;
      k = it.key;
      below = 0;
      not_above = 0;
      foreach (held_keys[i]) begin
         if (held_keys[i] < k) below++;
         if (held_keys[i] <= k) not_above++;
      end
      unique case (it.opcode)
         OP_INSERT: begin
            if (held_keys.size() >= CAPACITY) r.status = ST_FULL;
            else held_keys.insert(not_above, k);
         end
         OP_DELETE: begin
            if (below >= held_keys.size() || held_keys[below] != k) r.status = ST_MISS;
            else held_keys.delete(below);
         end
         OP_RANK: r.answer = below + 1;
         OP_KTH: begin
            if (it.position == 0 || it.position > held_keys.size()) r.status = ST_MISS;
            else r.answer = held_keys[it.position - 1];
         end
         OP_PRED: begin
            if (below == 0) r.status = ST_MISS;
            else r.answer = held_keys[below - 1];
         end
         OP_SUCC: begin
            if (not_above >= held_keys.size()) r.status = ST_MISS;
            else r.answer = held_keys[not_above];
         end
         default: r.status = ST_MISS;
      endcase
      return r;
   endfunction

   function automatic op_item_type make_op(logic [OP_W-1:0] op, logic [KEY_W-1:0] key,
                                           int unsigned pos);
      op_item_type it;
      it.opcode = op;
      it.key = key;
      it.position = POS_W'(pos);
      return it;
   endfunction

   // Keys mostly from a small pool so that duplicates, deletes and neighbours hit.
   function automatic logic [KEY_W-1:0] pick_key();
      unique case ($urandom_range(0, 9))
         0: return $urandom();
         1: return 32'h8000_0000 + $urandom_range(0, 3);
         2: return 32'h7FFF_FFFF - $urandom_range(0, 3);
         default: return $urandom_range(0, 40) - 20;
      endcase
   endfunction

   function automatic op_item_type random_op();
      int sel;
      sel = $urandom_range(0, 99);
      if (sel < 35) return make_op(OP_INSERT, pick_key(), $urandom());
      if (sel < 55) return make_op(OP_DELETE, pick_key(), $urandom());
      if (sel < 65) return make_op(OP_RANK, pick_key(), $urandom());
      if (sel < 80) return make_op(OP_KTH, $urandom(),
                                   ($urandom_range(0, 9) == 0) ? $urandom() :
                                   $urandom_range(0, 40));
      if (sel < 88) return make_op(OP_PRED, pick_key(), $urandom());
      if (sel < 96) return make_op(OP_SUCC, pick_key(), $urandom());
      return make_op(OP_W'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI)), $urandom(),
                     $urandom());
   endfunction

   // Driver: presents queued transactions, idling at random between them.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (req_tvalid) pending_ops.pop_front();
         if (pending_ops.size() != 0
             && $urandom_range(0, 99) >= send_idle_pct) begin
            req_tvalid <= 1'b1;
            req_tdata  <= {2'b00, pending_ops[0]};
            expected_results.push_back(apply_op(pending_ops[0]));
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Monitor: receiver back-pressure and comparison of each result transaction.
   always @(posedge clock) begin
      op_result_type got;
      op_result_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[33:0];
            if (expected_results.size() == 0) begin
               $error("unexpected result: answer %0d status %0d", got.answer, got.status);
               failures++;
            end else begin
               want = expected_results.pop_front();
               if (got.answer !== want.answer) begin
                  $error("answer: expected %0d, got %0d", $signed(want.answer),
                         $signed(got.answer));
                  failures++;
               end
               if (got.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, got.status);
                  failures++;
               end
            end
         end
      end
   end

   // Watchdog on cycles without any accepted transaction.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || reset)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   task automatic wait_drained();
      while (pending_ops.size() != 0 || req_tvalid || expected_results.size() != 0)
         @(posedge clock);
   endtask

   // Stimulus: directed corner cases, three random phases with idling changes,
   // then a fill to capacity with twenty deletes and random operations at the top.
   initial begin
      int fill_count;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      pending_ops.push_back(make_op(OP_KTH, 0, 1));
      pending_ops.push_back(make_op(OP_PRED, 0, 0));
      pending_ops.push_back(make_op(OP_SUCC, 0, 0));
      pending_ops.push_back(make_op(OP_DELETE, 5, 0));
      pending_ops.push_back(make_op(OP_RANK, 32'h8000_0000, 0));
      pending_ops.push_back(make_op(OP_INSERT, 32'h8000_0000, 11'h7FF));
      pending_ops.push_back(make_op(OP_INSERT, 32'h7FFF_FFFF, 0));
      pending_ops.push_back(make_op(OP_INSERT, 7, 0));
      pending_ops.push_back(make_op(OP_INSERT, 7, 0));
      pending_ops.push_back(make_op(OP_RANK, 32'h7FFF_FFFF, 0));
      pending_ops.push_back(make_op(OP_KTH, 0, 0));
      pending_ops.push_back(make_op(OP_KTH, 0, 4));
      pending_ops.push_back(make_op(OP_KTH, 0, 5));
      pending_ops.push_back(make_op(OP_KTH, 0, 11'h7FF));
      pending_ops.push_back(make_op(OP_PRED, 32'h8000_0000, 0));
      pending_ops.push_back(make_op(OP_SUCC, 32'h7FFF_FFFF, 0));
      pending_ops.push_back(make_op(OP_PRED, 7, 0));
      pending_ops.push_back(make_op(OP_SUCC, 7, 0));
      pending_ops.push_back(make_op(OP_DELETE, 7, 0));
      pending_ops.push_back(make_op(OP_DELETE, 8, 0));
      pending_ops.push_back(make_op(OP_UNUSED_LO, 32'hFFFF_FFFF, 11'h7FF));
      pending_ops.push_back(make_op(OP_UNUSED_HI, 0, 0));
      wait_drained();

      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 32 : (phase == 1) ? 63 : 0;
         recv_idle_pct = (phase == 0) ? 63 : (phase == 1) ? 32 : 0;
         for (int i = 0; i < 40; i++) pending_ops.push_back(random_op());
         wait_drained();
      end

      // Fill to capacity with full inserts rejected, then work near the top.
      fill_count = CAPACITY - held_keys.size() + 3;
      for (int i = 0; i < fill_count; i++)
         pending_ops.push_back(make_op(OP_INSERT, $urandom(), 0));
      pending_ops.push_back(make_op(OP_KTH, 0, CAPACITY));
      pending_ops.push_back(make_op(OP_KTH, 0, CAPACITY + 1));
      wait_drained();
      for (int i = 0; i < 20; i++)
         pending_ops.push_back(make_op(OP_DELETE, held_keys[i * 50], 0));
      wait_drained();
      for (int i = 0; i < 20; i++) pending_ops.push_back(random_op());
      wait_drained();

      repeat (50) @(posedge clock);
      if (failures == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end
endmodule

// ===== files.f =====
rtl/core/osm_pkg.sv
rtl/core/osm_ram.sv
rtl/core/order_statistic_multiset.sv
tb/order_statistic_multiset_tb.sv
